// ===== rtl/hss_pkg.sv =====
// ----------------------------------------------------------------------------
// hss_pkg: shared constants and types of the heat stencil sweep
// Register indexes, field widths, fixed-point constants, classification type.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

  localparam int MAX_GRID_DEF = 1024;
  localparam int GRID_MIN     = 3;
  localparam int FRAC_BITS    = 16;
  localparam int Q_DEPTH      = 4;

  // stream widths
  localparam int VAL_W        = 32;
  localparam int POS_W        = 10;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 56;

  // configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 19;
  localparam int GSIZE_W      = 11;
  localparam int WGT_W        = 18;
  localparam int DIAG_W       = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_V   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_H   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_V     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_H     = 3'd4;

  localparam logic [GSIZE_W-1:0]       GSIZE_RST  = 11'd1024;
  localparam logic signed [WGT_W-1:0]  WGT_RST    = 18'sd16384;  // 0.25
  localparam logic signed [DIAG_W-1:0] DIAG_RST   = 19'sd0;

  // what the back end has to do with one item
  typedef struct packed {
    logic upd;        // row above exists: emit its updated point
    logic on_border;  // updated point lies on the grid border: pass it
    logic last_row;   // item itself is on the final row: emit it too
    logic frame_end;  // item is the final grid point
  } hss_cls_t;

  localparam int CLS_W = $bits(hss_cls_t);

endpackage

`default_nettype wire

// ===== rtl/hss_ram.sv =====
// ----------------------------------------------------------------------------
// hss_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hss_front.sv =====
// ----------------------------------------------------------------------------
// hss_front: raster position tracking and item classification
// Takes grid points, tags each with its row, column and border class.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_front #(
  parameter  int MAX_GRID = hss_pkg::MAX_GRID_DEF,
  localparam int PW       = $clog2(MAX_GRID)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [hss_pkg::GSIZE_W-1:0]    grid_size,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hss_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           q_full,
  output logic                           push,
  output logic [hss_pkg::VAL_W-1:0]      push_sample,
  output logic [PW-1:0]                  push_row,
  output logic [PW-1:0]                  push_col,
  output hss_pkg::hss_cls_t              push_cls
);
  import hss_pkg::*;

  localparam int CW = $clog2(MAX_GRID + 1);
  localparam int NW = (CW > GSIZE_W) ? CW : GSIZE_W;

  logic [PW-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [NW-1:0] n, gs, r_w, c_w;
  logic [PW-1:0] r, c;
  logic          wrap;

  assign gs = NW'(grid_size);
  always_comb begin
    if (gs < NW'(GRID_MIN)) begin
      n = NW'(GRID_MIN);
    end else if (gs > NW'(MAX_GRID)) begin
      n = NW'(MAX_GRID);
    end else begin
      n = gs;
    end
  end

  // a position beyond the grid in use restarts the sweep
  assign wrap = (NW'(row_r) >= n) || (NW'(col_r) >= n);
  assign r    = wrap ? '0 : row_r;
  assign c    = wrap ? '0 : col_r;
  assign r_w  = NW'(r);
  assign c_w  = NW'(c);

  assign in_tready   = !q_full;
  assign push        = in_tvalid && in_tready;
  assign push_sample = in_tdata[VAL_W-1:0];
  assign push_row    = r;
  assign push_col    = c;

  always_comb begin
    push_cls.upd       = (r_w != '0);
    push_cls.on_border = (r_w == NW'(1)) || (c_w == '0) || (c_w == n - NW'(1));
    push_cls.last_row  = (r_w == n - NW'(1));
    push_cls.frame_end = (r_w == n - NW'(1)) && (c_w == n - NW'(1));
  end

  always_comb begin
    row_nxt = r;
    col_nxt = c + PW'(1);
    if (c_w + NW'(1) >= n) begin
      col_nxt = '0;
      row_nxt = (r_w + NW'(1) >= n) ? '0 : r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (push) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hss_queue.sv =====
// ----------------------------------------------------------------------------
// hss_queue: small FIFO between front and back end
// Register-based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_queue #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = hss_pkg::Q_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [AW:0]      cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hss_back.sv =====
// ----------------------------------------------------------------------------
// hss_back: line stores, stencil arithmetic and result register
// Sequences one item at a time through reads, products and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_back #(
  parameter  int MAX_GRID = hss_pkg::MAX_GRID_DEF,
  localparam int PW       = $clog2(MAX_GRID)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  logic [hss_pkg::VAL_W-1:0]        q_sample,
  input  logic [PW-1:0]                    q_row,
  input  logic [PW-1:0]                    q_col,
  input  hss_pkg::hss_cls_t                q_cls,
  input  logic signed [hss_pkg::WGT_W-1:0]  wv,
  input  logic signed [hss_pkg::WGT_W-1:0]  wh,
  input  logic signed [hss_pkg::DIAG_W-1:0] dv,
  input  logic signed [hss_pkg::DIAG_W-1:0] dh,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hss_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser
);
  import hss_pkg::*;

  localparam int PRD_W = VAL_W + DIAG_W;          // centre * diag
  localparam int SUM_W = VAL_W + 5;               // neighbor sum
  localparam int WPR_W = SUM_W + WGT_W;           // weight * sum
  localparam int ACC_W = WPR_W - FRAC_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_RIGHT, ST_VSUM, ST_WMUL, ST_ACC, ST_EMIT_UPD, ST_EMIT_ROW
  } state_t;

  state_t                   state_r;
  logic signed [VAL_W-1:0]  sample_r, centre_r, up_r, left_r, right_r, res_r;
  logic [PW-1:0]            row_r, col_r;
  hss_cls_t                 cls_r;
  logic signed [PRD_W-1:0]  pv_r, ph_r;
  logic signed [SUM_W-1:0]  vsum_r, hsum_r;
  logic signed [WPR_W-1:0]  qv_r, qh_r;

  logic                     out_valid_r, out_last_r, out_done_r;
  logic [VAL_W-1:0]         out_val_r;
  logic [POS_W-1:0]         out_row_r, out_col_r;

  logic                     ram_re, ram_we, out_load, out_fire;
  logic [PW-1:0]            ram_raddr, next_col;
  logic [2*VAL_W-1:0]       ram_rdata, ram_wdata;
  logic signed [VAL_W-1:0]  rd_above, rd_two;
  logic signed [ACC_W-1:0]  acc;
  logic signed [VAL_W-1:0]  acc_sat;

  // one entry per column: upper half two rows up, lower half one row up
  hss_ram #(.WIDTH(2*VAL_W), .DEPTH(MAX_GRID)) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_above  = $signed(ram_rdata[VAL_W-1:0]);
  assign rd_two    = $signed(ram_rdata[2*VAL_W-1:VAL_W]);
  assign next_col  = (col_r == PW'(MAX_GRID - 1)) ? col_r : col_r + PW'(1);
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_re    = q_pop || (state_r == ST_READ);
  assign ram_raddr = (state_r == ST_READ) ? next_col : q_col;
  assign ram_we    = (state_r == ST_READ);
  assign ram_wdata = {ram_rdata[VAL_W-1:0], sample_r};
  assign out_load  = !out_valid_r || out_tready;
  assign out_fire  = ((state_r == ST_EMIT_UPD) || (state_r == ST_EMIT_ROW)) && out_load;

  assign acc = ACC_W'(qv_r >>> FRAC_BITS) + ACC_W'(qh_r >>> FRAC_BITS);
  always_comb begin
    if (acc > ACC_W'(32'sh7FFF_FFFF)) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc < ACC_W'(-33'sh0_8000_0000)) begin
      acc_sat = -32'sh8000_0000;
    end else begin
      acc_sat = VAL_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            sample_r <= $signed(q_sample);
            row_r    <= q_row;
            col_r    <= q_col;
            cls_r    <= q_cls;
            state_r  <= ST_READ;
          end
        end
        ST_READ: begin
          // previous item's centre is the left neighbor of this one
          left_r   <= centre_r;
          centre_r <= rd_above;
          up_r     <= rd_two;
          state_r  <= ST_RIGHT;
        end
        ST_RIGHT: begin
          right_r <= rd_above;
          pv_r    <= PRD_W'(centre_r) * PRD_W'(dv);
          ph_r    <= PRD_W'(centre_r) * PRD_W'(dh);
          res_r   <= centre_r;
          if (!cls_r.upd) begin
            state_r <= cls_r.last_row ? ST_EMIT_ROW : ST_IDLE;
          end else if (cls_r.on_border) begin
            state_r <= ST_EMIT_UPD;
          end else begin
            state_r <= ST_VSUM;
          end
        end
        ST_VSUM: begin
          vsum_r  <= SUM_W'(up_r) + SUM_W'(sample_r) + SUM_W'(pv_r >>> FRAC_BITS);
          hsum_r  <= SUM_W'(left_r) + SUM_W'(right_r) + SUM_W'(ph_r >>> FRAC_BITS);
          state_r <= ST_WMUL;
        end
        ST_WMUL: begin
          qv_r    <= WPR_W'(wv) * WPR_W'(vsum_r);
          qh_r    <= WPR_W'(wh) * WPR_W'(hsum_r);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          res_r   <= acc_sat;
          state_r <= ST_EMIT_UPD;
        end
        ST_EMIT_UPD: begin
          if (out_load) begin
            out_val_r   <= res_r;
            out_row_r   <= POS_W'(row_r - PW'(1));
            out_col_r   <= POS_W'(col_r);
            out_done_r  <= 1'b0;
            out_last_r  <= !cls_r.last_row;
            state_r     <= cls_r.last_row ? ST_EMIT_ROW : ST_IDLE;
          end
        end
        ST_EMIT_ROW: begin
          if (out_load) begin
            out_val_r   <= sample_r;
            out_row_r   <= POS_W'(row_r);
            out_col_r   <= POS_W'(col_r);
            out_done_r  <= cls_r.frame_end;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - VAL_W - 2*POS_W)'(0), out_col_r, out_row_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

`default_nettype wire

// ===== rtl/heat_stencil_sweep.sv =====
// ----------------------------------------------------------------------------
// heat_stencil_sweep: one explicit five-point heat-equation sweep
// Raster-order grid points in, updated points of the row above out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | tdata[31:0] sample
//  out_    | out | out_tvalid/out_tready | tdata: value, row, col; tlast run_last;
//          |     |                       | tuser frame_done
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data[18:0]
//
// In the back end a first-row item only passes the reads, a border point
// the update emit too, an interior point also sum, multiply, accumulate;
// a final-row item emits once more. The sequencer shares the line-store
// read port for centre and right-neighbor reads; two multiply stages run.
// A 4-entry queue lets the input keep flowing while the back end works.
// Reset (rst_n low, synchronous) restarts at point (0,0) and loads the
// default coefficients; line-store contents are not cleared.
// Stalls on out_tready hold the result register and back the queue up.
// ----------------------------------------------------------------------------
`default_nettype none

module heat_stencil_sweep #(
  parameter int MAX_GRID = hss_pkg::MAX_GRID_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hss_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] sample
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hss_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] new_value, [41:32] out_row,
                                                      // [51:42] out_col, [55:52] zero
  output logic                            out_tlast,  // run_last
  output logic                            out_tuser,  // [0] frame_done
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hss_pkg::*;

  localparam int PW = $clog2(MAX_GRID);
  localparam int QW = CLS_W + 2*PW + VAL_W;

  logic [GSIZE_W-1:0]       grid_size_r;
  logic signed [WGT_W-1:0]  wv_r, wh_r;
  logic signed [DIAG_W-1:0] dv_r, dh_r;

  logic             push, q_full, q_valid, q_pop;
  logic [VAL_W-1:0] push_sample;
  logic [PW-1:0]    push_row, push_col;
  hss_cls_t         push_cls;
  logic [QW-1:0]    q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GSIZE_RST;
      wv_r        <= WGT_RST;
      wh_r        <= WGT_RST;
      dv_r        <= DIAG_RST;
      dh_r        <= DIAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_SIZE: grid_size_r <= cfg_data[GSIZE_W-1:0];
        CFG_WEIGHT_V:  wv_r        <= $signed(cfg_data[WGT_W-1:0]);
        CFG_WEIGHT_H:  wh_r        <= $signed(cfg_data[WGT_W-1:0]);
        CFG_DIAG_V:    dv_r        <= $signed(cfg_data[DIAG_W-1:0]);
        CFG_DIAG_H:    dh_r        <= $signed(cfg_data[DIAG_W-1:0]);
        default: ;
      endcase
    end
  end

  hss_front #(.MAX_GRID(MAX_GRID)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_size   (grid_size_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .q_full      (q_full),
    .push        (push),
    .push_sample (push_sample),
    .push_row    (push_row),
    .push_col    (push_col),
    .push_cls    (push_cls)
  );

  hss_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_cls, push_row, push_col, push_sample}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  hss_back #(.MAX_GRID(MAX_GRID)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_sample   (q_head[VAL_W-1:0]),
    .q_row      (q_head[VAL_W+2*PW-1:VAL_W+PW]),
    .q_col      (q_head[VAL_W+PW-1:VAL_W]),
    .q_cls      (q_head[QW-1:QW-CLS_W]),
    .wv         (wv_r),
    .wh         (wh_r),
    .dv         (dv_r),
    .dh         (dh_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/hss_checker.sv =====
// ----------------------------------------------------------------------------
// hss_checker: port-level checks of the heat stencil sweep
// Watches the top-level ports only; bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hss_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  // no result comes out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // the final grid point ends its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame_done without run_last");

  // the final point of a square grid sits on the diagonal
  a_done_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[41:32] == out_tdata[51:42])
    else $error("frame_done off the diagonal");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind heat_stencil_sweep hss_checker u_hss_checker (.*);

`default_nettype wire

// ===== dv/tb_heat_stencil_sweep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heat_stencil_sweep: self-checking bench for the five-point heat sweep
// Streams raster-order grids of many sizes, coefficient sets and contents
// through the block with random gaps on both sides. A predictor tracks the
// line stores and coefficients and checks every emitted point in order.
// ----------------------------------------------------------------------------

module tb_heat_stencil_sweep;
  import hss_pkg::*;

  localparam int GRID_CAP      = MAX_GRID_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 135;
  localparam int PRINT_CAP     = 40;

  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int ONE_Q16       = 65536;
  localparam int QUARTER_Q16   = 16384;
  localparam int MINUS_TWO_Q16 = -131072;
  localparam int WGT_MAX       = (1 << (WGT_W - 1)) - 1;
  localparam int WGT_MIN       = -(1 << (WGT_W - 1));
  localparam int DIAG_MAX      = (1 << (DIAG_W - 1)) - 1;
  localparam int DIAG_MIN      = -(1 << (DIAG_W - 1));
  localparam int GSIZE_TOP     = (1 << GSIZE_W) - 1;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    frame_done;
    logic                    run_last;
  } grid_point_t;

  class sweep_scoreboard;
    logic signed [VAL_W-1:0] line_above [GRID_CAP];
    logic signed [VAL_W-1:0] line_two_above [GRID_CAP];
    int unsigned             row_pos;
    int unsigned             col_pos;
    logic [GSIZE_W-1:0]      grid_size;
    logic signed [WGT_W-1:0] wv;
    logic signed [WGT_W-1:0] wh;
    logic signed [DIAG_W-1:0] dv;
    logic signed [DIAG_W-1:0] dh;
    grid_point_t             pending_q[$];
    int                      errors;

    function new();
      foreach (line_above[i]) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      row_pos   = 0;
      col_pos   = 0;
      grid_size = GSIZE_RST;
      wv        = WGT_RST;
      wh        = WGT_RST;
      dv        = DIAG_RST;
      dh        = DIAG_RST;
      errors    = 0;
    endfunction

    function int unsigned size_in_use();
      if (grid_size < GRID_MIN) return GRID_MIN;
      if (grid_size > GRID_CAP) return GRID_CAP;
      return grid_size;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_SIZE: grid_size = data[GSIZE_W-1:0];
        CFG_WEIGHT_V:  wv = data[WGT_W-1:0];
        CFG_WEIGHT_H:  wh = data[WGT_W-1:0];
        CFG_DIAG_V:    dv = data[DIAG_W-1:0];
        CFG_DIAG_H:    dh = data[DIAG_W-1:0];
        default: ;
      endcase
    endfunction

    // floor division by 2^16 on a signed product
    function longint drop_q16(longint x);
      return x >>> FRAC_BITS;
    endfunction

    function void note_sample(logic signed [VAL_W-1:0] s);
      int unsigned n, r, c;
      logic signed [VAL_W-1:0] centre, v;
      longint vsum, hsum, acc;
      n = size_in_use();
      if (row_pos >= n || col_pos >= n) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (r >= 1) begin
        centre = line_above[c];
        if (r == 1 || c == 0 || c == n - 1) begin
          v = centre;
        end else begin
          // left neighbor already moved down: line_two_above holds row r-1 there
          vsum = longint'(line_two_above[c]) + longint'(s)
               + drop_q16(longint'(centre) * longint'(dv));
          hsum = longint'(line_two_above[c-1]) + longint'(line_above[c+1])
               + drop_q16(longint'(centre) * longint'(dh));
          acc  = drop_q16(longint'(wv) * vsum) + drop_q16(longint'(wh) * hsum);
          if (acc > longint'(VAL_MAX)) v = VAL_MAX;
          else if (acc < longint'(VAL_MIN)) v = VAL_MIN;
          else v = acc[VAL_W-1:0];
        end
        pending_q.push_back('{v, POS_W'(r - 1), POS_W'(c), 1'b0, r != n - 1});
      end
      line_two_above[c] = line_above[c];
      line_above[c]     = s;
      if (r == n - 1)
        pending_q.push_back('{s, POS_W'(r), POS_W'(c), c == n - 1, 1'b1});
      col_pos = c + 1;
      if (col_pos >= n) begin
        col_pos = 0;
        row_pos = (r + 1 >= n) ? 0 : r + 1;
      end
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [VAL_W-1:0] value, logic [POS_W-1:0] row,
                      logic [POS_W-1:0] col, logic frame_done, logic run_last);
      grid_point_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected point (%0d,%0d) value %0d", row, col, value));
        return;
      end
      want = pending_q.pop_front();
      if (value !== want.value)
        report($sformatf("point (%0d,%0d) value %0d, want %0d", want.row, want.col,
                         value, want.value));
      if (row !== want.row)
        report($sformatf("row %0d, want %0d", row, want.row));
      if (col !== want.col)
        report($sformatf("col %0d, want %0d", col, want.col));
      if (frame_done !== want.frame_done)
        report($sformatf("point (%0d,%0d) frame_done %b, want %b", want.row, want.col,
                         frame_done, want.frame_done));
      if (run_last !== want.run_last)
        report($sformatf("point (%0d,%0d) run_last %b, want %b", want.row, want.col,
                         run_last, want.run_last));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [31:0] sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [31:0] new_value, [41:32] out_row,
                                             // [51:42] out_col, [55:52] zero
  logic                   out_tlast;         // run_last
  logic                   out_tuser;         // [0] frame_done
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  sweep_scoreboard sb;
  int in_calm  = 0;
  int out_calm = 0;
  int stall_left = 0;
  int random_items = 0;

  heat_stencil_sweep uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 3) begin
      calm = $urandom_range(40, 160);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 920) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap(out_calm);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[VAL_W-1:0], out_tdata[VAL_W+POS_W-1:VAL_W],
                      out_tdata[VAL_W+2*POS_W-1:VAL_W+POS_W], out_tuser, out_tlast);
  end

  // register word: value in the low bits, sometimes junk above the field
  function automatic logic [CFG_DATA_W-1:0] reg_word(int w, int value);
    logic [CFG_DATA_W-1:0] mask, word;
    mask = (CFG_DATA_W'(1) << w) - 1'b1;
    word = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
    return (word & ~mask) | (CFG_DATA_W'(value) & mask);
  endfunction

  function automatic int pick_coef(int w, int typical);
    case ($urandom_range(0, 4))
      0:       return -(1 << (w - 1));
      1:       return (1 << (w - 1)) - 1;
      2:       return typical;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_grid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, GRID_MIN - 1);  // clamps up to the minimum
    if (r < 75) return $urandom_range(GRID_MIN, 8);
    return $urandom_range(9, 16);
  endfunction

  function automatic logic [VAL_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(0, 4 * ONE_Q16);
        return $urandom_range(0, 1) ? -v : v;
      end
      default: return $urandom;
    endcase
  endfunction

  // a size change mid-sweep must not make the block read a line-store entry
  // that this sweep has not written
  function automatic bit size_change_ok(int unsigned n_req);
    int unsigned n_eff;
    n_eff = (n_req < GRID_MIN) ? GRID_MIN : n_req;
    if (sb.row_pos == 0 && sb.col_pos == 0) return 1'b1;
    if (sb.row_pos >= n_eff || sb.col_pos >= n_eff) return 1'b1;
    return n_eff <= sb.size_in_use() && sb.row_pos >= 2;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  task automatic send_sample(logic [VAL_W-1:0] s);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
  endtask

  // wait for all points, then let items that emit nothing leave the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic feed_random(int count);
    repeat (count) send_sample(pick_sample());
    settle();
  endtask

  initial begin
    logic [VAL_W-1:0] frames [3][9];
    int unsigned n_new, n, count;

    frames = '{
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff},
      '{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000},
      '{32'h0000_0000, 32'h0001_0000, 32'hffff_ffff, 32'h0001_0000, 32'h0003_0007,
        32'hffff_0000, 32'h0000_0001, 32'h0002_0000, 32'h8000_0000}
    };
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // largest grid, reset coefficients: first row and the wrap into the second
    cfg_write(CFG_GRID_SIZE, reg_word(GSIZE_W, GSIZE_TOP));
    cfg_valid <= 1'b0;
    feed_random(GRID_CAP + 6);

    // size below the minimum leaves the position past the last column: new sweep
    cfg_write(CFG_GRID_SIZE, reg_word(GSIZE_W, 0));
    cfg_write(CFG_WEIGHT_V, reg_word(WGT_W, WGT_MAX));
    cfg_write(CFG_WEIGHT_H, reg_word(WGT_W, WGT_MIN));
    cfg_write(CFG_DIAG_V, reg_word(DIAG_W, DIAG_MAX));
    cfg_write(CFG_DIAG_H, reg_word(DIAG_W, DIAG_MIN));
    cfg_write(CFG_SPARE, reg_word(CFG_DATA_W, int'($urandom)));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 9; i++) send_sample(frames[0][i]);
    settle();

    cfg_write(CFG_WEIGHT_V, reg_word(WGT_W, WGT_MIN));
    cfg_write(CFG_WEIGHT_H, reg_word(WGT_W, WGT_MAX));
    cfg_write(CFG_DIAG_V, reg_word(DIAG_W, DIAG_MIN));
    cfg_write(CFG_DIAG_H, reg_word(DIAG_W, DIAG_MAX));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 9; i++) send_sample(frames[1][i]);
    settle();

    // textbook heat update: 0.25 weights, -2.0 centre factors
    cfg_write(CFG_GRID_SIZE, reg_word(GSIZE_W, GRID_MIN));
    cfg_write(CFG_WEIGHT_V, reg_word(WGT_W, QUARTER_Q16));
    cfg_write(CFG_WEIGHT_H, reg_word(WGT_W, QUARTER_Q16));
    cfg_write(CFG_DIAG_V, reg_word(DIAG_W, MINUS_TWO_Q16));
    cfg_write(CFG_DIAG_H, reg_word(DIAG_W, MINUS_TWO_Q16));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 9; i++) send_sample(frames[2][i]);
    settle();

    // shrink the grid mid-sweep while still inside it: sweep carries on
    cfg_write(CFG_GRID_SIZE, reg_word(GSIZE_W, 12));
    cfg_write(CFG_DIAG_V, reg_word(DIAG_W, ONE_Q16));
    cfg_valid <= 1'b0;
    feed_random(4 * 12);
    cfg_write(CFG_GRID_SIZE, reg_word(GSIZE_W, 6));
    cfg_valid <= 1'b0;
    feed_random(2 * 6);

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        n_new = pick_grid();
        if (size_change_ok(n_new)) cfg_write(CFG_GRID_SIZE, reg_word(GSIZE_W, n_new));
      end
      if ($urandom_range(0, 1))
        cfg_write(CFG_WEIGHT_V, reg_word(WGT_W,
                  pick_coef(WGT_W, $urandom_range(0, 1) ? QUARTER_Q16 : ONE_Q16)));
      if ($urandom_range(0, 1))
        cfg_write(CFG_WEIGHT_H, reg_word(WGT_W,
                  pick_coef(WGT_W, $urandom_range(0, 1) ? QUARTER_Q16 : ONE_Q16)));
      if ($urandom_range(0, 1))
        cfg_write(CFG_DIAG_V, reg_word(DIAG_W,
                  pick_coef(DIAG_W, $urandom_range(0, 1) ? MINUS_TWO_Q16 : 0)));
      if ($urandom_range(0, 1))
        cfg_write(CFG_DIAG_H, reg_word(DIAG_W,
                  pick_coef(DIAG_W, $urandom_range(0, 1) ? MINUS_TWO_Q16 : 0)));
      cfg_valid <= 1'b0;
      n = sb.size_in_use();
      count = n * n * $urandom_range(1, 2);
      // sometimes stop mid-sweep so the next size change can cut it short
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, n * n - 1);
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      feed_random(count);
      random_items += count;
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb_heat_stencil_sweep OK");
    else
      $display("tb_heat_stencil_sweep NOT OK");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_heat_stencil_sweep NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hss_pkg.sv
rtl/hss_ram.sv
rtl/hss_front.sv
rtl/hss_queue.sv
rtl/hss_back.sv
rtl/heat_stencil_sweep.sv
rtl/hss_checker.sv
dv/tb_heat_stencil_sweep.sv
